FILE: hdl/pbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbb_pkg: shared types and constants of the path bounding box block
// Coordinate and coefficient widths, the command codes, the queue entry and
// the handshake structs of the root solver, and the curve evaluation steps.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COORD_W = 32;   // internal coordinate width
  localparam int COEF_W  = 36;   // derivative coefficients
  localparam int DISC_W  = 72;   // cubic discriminant, signed
  localparam int ROOT_W  = 36;   // square root result
  localparam int REM_W   = 38;   // solver remainder
  localparam int T_FRAC  = 28;   // t is unsigned Q1.28
  localparam int T_W     = T_FRAC + 1;
  localparam int CHUNK_W = 18;   // multiplier operand slice
  localparam int SQRT_STEPS = DISC_W / 2;
  localparam int DIV_STEPS  = T_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef enum logic [1:0] {
    CMD_LINE   = 2'd0,
    CMD_QUAD   = 2'd1,
    CMD_CUBIC  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  // one axis of a segment: control points and derivative coefficients
  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
    coef_t  qa;
    coef_t  qb;
    coef_t  qc;
  } axis_t;

  typedef struct packed {
    cmd_t  cmd;
    axis_t ax_x;
    axis_t ax_y;
  } item_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } solve_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
  } solve_rsp_t;

  typedef enum logic [1:0] {
    EOP_LERP = 2'd0,
    EOP_DROP = 2'd1,
    EOP_END  = 2'd2
  } eop_t;

  // de Casteljau on a four-slot shift queue: a lerp pops the head, reads the
  // next slot and appends; a drop discards the head. The result ends in slot 3.
  function automatic eop_t eval_op(input logic cubic, input logic [3:0] idx);
    eop_t op;
    op = EOP_END;
    if (cubic) begin
      case (idx)
        4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd8: op = EOP_LERP;
        4'd3, 4'd6, 4'd7:                   op = EOP_DROP;
        default:                            op = EOP_END;
      endcase
    end else begin
      case (idx)
        4'd0, 4'd1, 4'd4: op = EOP_LERP;
        4'd2, 4'd3:       op = EOP_DROP;
        default:          op = EOP_END;
      endcase
    end
    return op;
  endfunction

endpackage

FILE: hdl/path_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_bounding_box: running bounding box of a Bezier path
// Input channel (in_valid/in_stall): one segment per transaction, a line,
// quadratic or cubic in signed Q16.16, or a finish command. Output channel
// (out_valid/out_stall): one box per finish, zeros with was_empty set when
// no segment came since reset or the previous finish; the box then clears.
// Segments pass a classifier into a two-entry queue; the executor takes one
// at a time. A cubic's run time is set by the shared solver (36-step square
// root and 29-step divisions for two roots per axis) and the lerp unit (six
// lerps per root). While the output is stalled the held box stays put, the
// next finish waits and up to two segments queue behind.
// Reset (rst, synchronous) empties the queue and clears the box.
// ----------------------------------------------------------------------------
module path_bounding_box
  import pbb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [1:0]  command,
  input  logic signed [31:0] p0_x,
  input  logic signed [31:0] p0_y,
  input  logic signed [31:0] p1_x,
  input  logic signed [31:0] p1_y,
  input  logic signed [31:0] p2_x,
  input  logic signed [31:0] p2_y,
  input  logic signed [31:0] p3_x,
  input  logic signed [31:0] p3_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] min_x,
  output logic signed [31:0] min_y,
  output logic signed [31:0] max_x,
  output logic signed [31:0] max_y,
  output logic               was_empty
);

  item_t in_item, head;
  logic  full, avail, pop;

  pbb_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .command (command),
    .p0_x    (p0_x),
    .p0_y    (p0_y),
    .p1_x    (p1_x),
    .p1_y    (p1_y),
    .p2_x    (p2_x),
    .p2_y    (p2_y),
    .p3_x    (p3_x),
    .p3_y    (p3_y),
    .item    (in_item)
  );

  assign in_stall = full;

  pbb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !full),
    .push_item (in_item),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  pbb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .min_x     (min_x),
    .min_y     (min_y),
    .max_x     (max_x),
    .max_y     (max_y),
    .was_empty (was_empty)
  );

endmodule

FILE: hdl/pbb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbb_fifo: two-entry segment queue
// Decouples the input classifier from the executor so that each side stalls on
// its own.
// ----------------------------------------------------------------------------
module pbb_fifo
  import pbb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  avail,
  output item_t head
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hdl/pbb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbb_front: segment classifier
// Sign-extends the control points and forms the derivative coefficients of
// both axes before the segment enters the queue.
// ----------------------------------------------------------------------------
module pbb_front
  import pbb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        [1:0]  command,
  input  logic signed [31:0] p0_x,
  input  logic signed [31:0] p0_y,
  input  logic signed [31:0] p1_x,
  input  logic signed [31:0] p1_y,
  input  logic signed [31:0] p2_x,
  input  logic signed [31:0] p2_y,
  input  logic signed [31:0] p3_x,
  input  logic signed [31:0] p3_y,
  output item_t              item
);

  localparam int EFF_W = (COORD_WIDTH < COORD_W) ? COORD_WIDTH : COORD_W;
  localparam int SHIFT = COORD_W - EFF_W;

  function automatic coord_t sext(input logic [31:0] v);
    logic [COORD_W-1:0] up;
    up = v << SHIFT;
    return $signed(up) >>> SHIFT;
  endfunction

  function automatic axis_t make_axis(input coord_t a, input coord_t b,
                                      input coord_t c, input coord_t d);
    axis_t r;
    coef_t a36, b36, c36, d36;
    a36  = COEF_W'(a);
    b36  = COEF_W'(b);
    c36  = COEF_W'(c);
    d36  = COEF_W'(d);
    r.a  = a;
    r.b  = b;
    r.c  = c;
    r.d  = d;
    r.qa = d36 - a36 + (b36 <<< 1) + b36 - (c36 <<< 1) - c36;
    r.qb = a36 - (b36 <<< 1) + c36;
    r.qc = b36 - a36;
    return r;
  endfunction

  always_comb begin
    item.cmd  = cmd_t'(command);
    item.ax_x = make_axis(sext(p0_x), sext(p1_x), sext(p2_x), sext(p3_x));
    item.ax_y = make_axis(sext(p0_y), sext(p1_y), sext(p2_y), sext(p3_y));
  end

endmodule

FILE: hdl/pbb_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbb_solver: iterative square root and divider
// Square root: two radicand bits a step, 36 steps. Division: rounded t of
// num/den in Q1.28, one quotient bit a step, 29 steps.
// ----------------------------------------------------------------------------
module pbb_solver
  import pbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  solve_req_t        req,
  input  logic [DISC_W-1:0] radicand,
  input  logic [COEF_W-1:0] num,
  input  logic [COEF_W-1:0] den,
  output solve_rsp_t        rsp
);

  logic              busy;
  logic              sq_mode;
  logic [5:0]        cnt;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] acc;
  logic [DISC_W-1:0] sh;
  logic [COEF_W-1:0] dv;
  logic              done_r;

  logic [63:0]       nfull;
  logic [REM_W-1:0]  r4, trial, r2, dv_ext;

  always_comb begin
    nfull  = {num, 28'b0} + {29'b0, den[COEF_W-1:1]};
    r4     = {rem[REM_W-3:0], sh[DISC_W-1 -: 2]};
    trial  = {acc, 2'b01};
    r2     = {rem[REM_W-2:0], sh[DISC_W-1]};
    dv_ext = {2'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sq_mode <= req.sqrt_mode;
      acc     <= '0;
      dv      <= den;
      if (req.sqrt_mode) begin
        rem <= '0;
        sh  <= radicand;
        cnt <= 6'(SQRT_STEPS - 1);
      end else begin
        rem <= {3'b0, nfull[63:T_W]};
        sh  <= {nfull[T_W-1:0], (DISC_W - T_W)'(0)};
        cnt <= 6'(DIV_STEPS - 1);
      end
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (sq_mode) begin
        sh <= sh << 2;
        if (r4 >= trial) begin
          rem <= r4 - trial;
          acc <= {acc[ROOT_W-2:0], 1'b1};
        end else begin
          rem <= r4;
          acc <= {acc[ROOT_W-2:0], 1'b0};
        end
      end else begin
        sh <= sh << 1;
        if (r2 >= dv_ext) begin
          rem <= r2 - dv_ext;
          acc <= {acc[ROOT_W-2:0], 1'b1};
        end else begin
          rem <= r2;
          acc <= {acc[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (cnt == 6'd0) && !req.start;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc;

endmodule

FILE: hdl/pbb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbb_back: segment executor
// Folds end points into the box, forms the cubic discriminant on a sliced
// multiplier, runs the solver for roots, evaluates the curve at each root
// with a shared lerp unit and emits the box on finish.
// ----------------------------------------------------------------------------
module pbb_back
  import pbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  item_t              head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] min_x,
  output logic signed [31:0] min_y,
  output logic signed [31:0] max_x,
  output logic signed [31:0] max_y,
  output logic               was_empty
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_POINTS = 10'b0000000010,
    S_AXIS   = 10'b0000000100,
    S_MUL    = 10'b0000001000,
    S_SQRT   = 10'b0000010000,
    S_ROOT   = 10'b0000100000,
    S_DIV    = 10'b0001000000,
    S_EVAL   = 10'b0010000000,
    S_NEXT   = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t state;
  item_t  cur;
  logic   axis;
  logic   root_sel;
  logic [1:0] mcnt;
  logic signed [DISC_W-1:0] disc;
  logic [ROOT_W-1:0] sq;
  logic [COEF_W-1:0] un_r, ud_r;
  logic [T_W-1:0]    t_val;
  logic   kick;
  coord_t pts [4];
  logic [3:0] eidx;
  logic   phase;
  logic signed [62:0] prod;
  coord_t box_left, box_right, box_top, box_bottom;
  logic   seen;

  solve_req_t req;
  solve_rsp_t rsp;

  pbb_solver u_solver (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .radicand (disc),
    .num      (un_r),
    .den      (ud_r),
    .rsp      (rsp)
  );

  assign req.start     = kick;
  assign req.sqrt_mode = (state == S_SQRT);

  function automatic coord_t smin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t smax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [COEF_W-1:0] mag36(input coef_t v);
    return v[COEF_W-1] ? COEF_W'(-v) : v;
  endfunction

  // current axis
  axis_t ax;
  logic  is_cubic, is_line;
  assign ax       = axis ? cur.ax_y : cur.ax_x;
  assign is_cubic = (cur.cmd == CMD_CUBIC);
  assign is_line  = (cur.cmd == CMD_LINE);

  // segment end points
  coord_t ex, ey, lo_x, hi_x, lo_y, hi_y;
  always_comb begin
    case (cur.cmd)
      CMD_LINE: begin
        ex = cur.ax_x.b;
        ey = cur.ax_y.b;
      end
      CMD_QUAD: begin
        ex = cur.ax_x.c;
        ey = cur.ax_y.c;
      end
      default: begin
        ex = cur.ax_x.d;
        ey = cur.ax_y.d;
      end
    endcase
    lo_x = smin(cur.ax_x.a, ex);
    hi_x = smax(cur.ax_x.a, ex);
    lo_y = smin(cur.ax_y.a, ey);
    hi_y = smax(cur.ax_y.a, ey);
  end

  // discriminant slice: qb*qb - qa*qc, one 36x18 partial product a cycle
  coef_t x_op, y_op;
  logic [COEF_W-1:0]  mx, my;
  logic [CHUNK_W-1:0] ych;
  logic [53:0]        term;
  logic [DISC_W-1:0]  term_w;
  logic signed [DISC_W-1:0] disc_next;
  always_comb begin
    x_op   = mcnt[1] ? ax.qa : ax.qb;
    y_op   = mcnt[1] ? ax.qc : ax.qb;
    mx     = mag36(x_op);
    my     = mag36(y_op);
    ych    = mcnt[0] ? my[COEF_W-1:CHUNK_W] : my[CHUNK_W-1:0];
    term   = mx * ych;
    term_w = mcnt[0] ? {term, 18'b0} : {18'b0, term};
    if (mcnt[1] && (x_op[COEF_W-1] == y_op[COEF_W-1])) begin
      disc_next = disc - $signed(term_w);
    end else begin
      disc_next = disc + $signed(term_w);
    end
  end

  // root ratio n/d
  logic signed [37:0] n_val;
  coef_t              d_val;
  logic [37:0]        un_w;
  logic [COEF_W-1:0]  ud_w;
  logic               root_ok;
  always_comb begin
    if (is_cubic) begin
      if (root_sel) begin
        n_val = -38'(ax.qb) + $signed({2'b0, sq});
      end else begin
        n_val = -38'(ax.qb) - $signed({2'b0, sq});
      end
      d_val = ax.qa;
    end else begin
      n_val = -38'(ax.qc);
      d_val = ax.qb;
    end
    un_w    = n_val[37] ? 38'(-n_val) : n_val;
    ud_w    = mag36(d_val);
    root_ok = (d_val != '0)
           && !((n_val != '0) && (n_val[37] != d_val[COEF_W-1]))
           && (un_w <= {2'b0, ud_w});
  end

  // lerp unit
  eop_t op;
  logic signed [32:0] diff;
  logic signed [62:0] rnd;
  coord_t             lerp_v;
  always_comb begin
    op     = eval_op(is_cubic, eidx);
    diff   = 33'(pts[1]) - 33'(pts[0]);
    rnd    = prod + 63'sd134217728;
    lerp_v = pts[0] + coord_t'(rnd >>> T_FRAC);
  end

  logic emit_go;
  assign emit_go = (state == S_EMIT) && (!out_valid || !out_stall);
  assign pop     = (state == S_IDLE) && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kick       <= 1'b0;
      seen       <= 1'b0;
      box_left   <= '0;
      box_right  <= '0;
      box_top    <= '0;
      box_bottom <= '0;
      out_valid  <= 1'b0;
    end else begin
      kick <= 1'b0;
      if (out_valid && !out_stall && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            cur   <= head;
            axis  <= 1'b0;
            state <= (head.cmd == CMD_FINISH) ? S_EMIT : S_POINTS;
          end
        end
        S_POINTS: begin
          seen       <= 1'b1;
          box_left   <= seen ? smin(box_left, lo_x) : lo_x;
          box_right  <= seen ? smax(box_right, hi_x) : hi_x;
          box_top    <= seen ? smin(box_top, lo_y) : lo_y;
          box_bottom <= seen ? smax(box_bottom, hi_y) : hi_y;
          state      <= is_line ? S_IDLE : S_AXIS;
        end
        S_AXIS: begin
          root_sel <= 1'b0;
          mcnt     <= 2'd0;
          disc     <= '0;
          if (!is_cubic) begin
            state <= S_ROOT;
          end else if (ax.qa == '0) begin
            state <= S_NEXT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          disc <= disc_next;
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            if (disc_next[DISC_W-1]) begin
              state <= S_NEXT;
            end else begin
              kick  <= 1'b1;
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (rsp.done) begin
            sq    <= rsp.result;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          un_r <= un_w[COEF_W-1:0];
          ud_r <= ud_w;
          if (root_ok) begin
            kick  <= 1'b1;
            state <= S_DIV;
          end else if (is_cubic && !root_sel) begin
            root_sel <= 1'b1;
          end else begin
            state <= S_NEXT;
          end
        end
        S_DIV: begin
          if (rsp.done) begin
            t_val  <= rsp.result[T_W-1:0];
            pts[0] <= ax.a;
            pts[1] <= ax.b;
            pts[2] <= ax.c;
            pts[3] <= ax.d;
            eidx   <= 4'd0;
            phase  <= 1'b0;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (op)
            EOP_LERP: begin
              if (!phase) begin
                prod  <= diff * $signed({1'b0, t_val});
                phase <= 1'b1;
              end else begin
                pts[0] <= pts[1];
                pts[1] <= pts[2];
                pts[2] <= pts[3];
                pts[3] <= lerp_v;
                phase  <= 1'b0;
                eidx   <= eidx + 4'd1;
              end
            end
            EOP_DROP: begin
              pts[0] <= pts[1];
              pts[1] <= pts[2];
              pts[2] <= pts[3];
              eidx   <= eidx + 4'd1;
            end
            default: begin
              if (axis) begin
                box_top    <= smin(box_top, pts[3]);
                box_bottom <= smax(box_bottom, pts[3]);
              end else begin
                box_left   <= smin(box_left, pts[3]);
                box_right  <= smax(box_right, pts[3]);
              end
              if (is_cubic && !root_sel) begin
                root_sel <= 1'b1;
                state    <= S_ROOT;
              end else begin
                state <= S_NEXT;
              end
            end
          endcase
        end
        S_NEXT: begin
          if (!axis) begin
            axis  <= 1'b1;
            state <= S_AXIS;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid  <= 1'b1;
            min_x      <= box_left;
            min_y      <= box_top;
            max_x      <= box_right;
            max_y      <= box_bottom;
            was_empty  <= !seen;
            seen       <= 1'b0;
            box_left   <= '0;
            box_right  <= '0;
            box_top    <= '0;
            box_bottom <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_SQRT || state == S_DIV))
    else $error("solver finished while no root was pending");

  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    !seen |-> (box_left == '0 && box_right == '0 && box_top == '0 && box_bottom == '0))
    else $error("box holds data with no segment seen");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (!seen && out_valid))
    else $error("finish did not clear the box or raise the result");

  a_t_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (t_val <= T_W'(1 << T_FRAC)))
    else $error("root parameter above one");

endmodule
